/* rtl/core/srcc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package srcc_pkg;
    localparam int FIELD_W    = 32;
    localparam int RHO_W      = 16;
    localparam int PTS_W      = 11;
    localparam int Q_W        = 15;
    localparam int Q2_W       = 29;
    localparam int FRAC_SHIFT = 28;
    localparam logic [Q_W-1:0] RHO_ONE = 15'd16384;
endpackage
`default_nettype wire

/* rtl/core/srcc_intf.sv */
`timescale 1ns / 1ps
`default_nettype none
interface srcc_in_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [srcc_pkg::FIELD_W-1:0] x_value;
    logic signed [srcc_pkg::FIELD_W-1:0] y_value;
    logic                                 last_point;
    modport source (output valid, x_value, y_value, last_point, input ready);
    modport sink (input valid, x_value, y_value, last_point, output ready);
endinterface

interface srcc_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [srcc_pkg::RHO_W-1:0] rho;
    logic                               degenerate;
    logic [srcc_pkg::PTS_W-1:0]        points_used;
    modport source (output valid, rho, degenerate, points_used, input ready);
    modport sink (input valid, rho, degenerate, points_used, output ready);
endinterface
`default_nettype wire

/* rtl/core/srcc_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
module srcc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

/* rtl/core/srcc_rank.sv */
`timescale 1ns / 1ps
`default_nettype none
module srcc_rank #(
    parameter int MAX_POINTS  = 1024,
    parameter int SAMPLE_BITS = 32
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   start,
    input  wire logic [$clog2(MAX_POINTS+1)-1:0]        n,
    output logic      [$clog2(MAX_POINTS)-1:0]          raddr,
    input  wire logic signed [SAMPLE_BITS-1:0]          x_key,
    input  wire logic signed [SAMPLE_BITS-1:0]          y_key,
    output logic                                        done,
    output logic      [3*$clog2(MAX_POINTS+1)-1:0]      sxx,
    output logic      [3*$clog2(MAX_POINTS+1)-1:0]      syy,
    output logic signed [3*$clog2(MAX_POINTS+1):0]      sxy
);
    localparam int CW    = $clog2(MAX_POINTS + 1);
    localparam int AW    = $clog2(MAX_POINTS);
    localparam int DW    = CW + 1;
    localparam int SUM_W = 3 * CW;

    localparam logic [2:0] R_IDLE  = 3'd0;
    localparam logic [2:0] R_KEY   = 3'd1;
    localparam logic [2:0] R_LATCH = 3'd2;
    localparam logic [2:0] R_SWEEP = 3'd3;
    localparam logic [2:0] R_DIFF  = 3'd4;
    localparam logic [2:0] R_PROD  = 3'd5;
    localparam logic [2:0] R_ACC   = 3'd6;

    logic [2:0]                    state_reg, state_next;
    logic [CW-1:0]                 i_reg, i_next, j_reg, j_next;
    logic                          cmp_reg, cmp_next;
    logic signed [SAMPLE_BITS-1:0] kx_reg, ky_reg;
    logic [CW-1:0]                 xl_reg, xe_reg, yl_reg, ye_reg;
    logic signed [DW-1:0]          ax_reg, ay_reg;
    logic signed [2*DW-1:0]        pxx_reg, pyy_reg, pxy_reg;
    logic [SUM_W-1:0]              sxx_reg, syy_reg;
    logic signed [SUM_W:0]         sxy_reg;
    logic                          done_reg;
    logic [CW+1:0]                 rank_x, rank_y;
    logic [CW+1:0]                 center;
    logic signed [CW+2:0]          diff_x, diff_y;

    assign rank_x = {xl_reg, 1'b0} + (CW+2)'(xe_reg) + (CW+2)'(1);
    assign rank_y = {yl_reg, 1'b0} + (CW+2)'(ye_reg) + (CW+2)'(1);
    assign center = (CW+2)'(n) + (CW+2)'(1);
    assign diff_x = $signed({1'b0, rank_x}) - $signed({1'b0, center});
    assign diff_y = $signed({1'b0, rank_y}) - $signed({1'b0, center});

    always_comb
    begin
        unique case (state_reg)
            R_KEY:   raddr = i_reg[AW-1:0];
            R_LATCH: raddr = '0;
            default: raddr = j_reg[AW-1:0];
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        cmp_next   = cmp_reg;
        unique case (state_reg)
            R_IDLE:
            begin
                if (start)
                begin
                    i_next     = '0;
                    state_next = R_KEY;
                end
            end
            R_KEY:   state_next = R_LATCH;
            R_LATCH:
            begin
                j_next     = CW'(1);
                cmp_next   = 1'b1;
                state_next = R_SWEEP;
            end
            R_SWEEP:
            begin
                cmp_next = (j_reg < n);
                if (j_reg < n)
                begin
                    j_next = j_reg + CW'(1);
                end
                if (!cmp_reg)
                begin
                    state_next = R_DIFF;
                end
            end
            R_DIFF:  state_next = R_PROD;
            R_PROD:  state_next = R_ACC;
            R_ACC:
            begin
                i_next     = i_reg + CW'(1);
                state_next = (i_reg + CW'(1) == n) ? R_IDLE : R_KEY;
            end
            default: state_next = R_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= R_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            cmp_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            cmp_reg   <= cmp_next;
            done_reg  <= (state_reg == R_ACC) && (i_reg + CW'(1) == n);
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == R_IDLE && start)
        begin
            sxx_reg <= '0;
            syy_reg <= '0;
            sxy_reg <= '0;
        end
        if (state_reg == R_LATCH)
        begin
            kx_reg <= x_key;
            ky_reg <= y_key;
            xl_reg <= '0;
            xe_reg <= '0;
            yl_reg <= '0;
            ye_reg <= '0;
        end
        if (state_reg == R_SWEEP && cmp_reg)
        begin
            if (x_key < kx_reg)
            begin
                xl_reg <= xl_reg + CW'(1);
            end
            else if (x_key == kx_reg)
            begin
                xe_reg <= xe_reg + CW'(1);
            end
            if (y_key < ky_reg)
            begin
                yl_reg <= yl_reg + CW'(1);
            end
            else if (y_key == ky_reg)
            begin
                ye_reg <= ye_reg + CW'(1);
            end
        end
        if (state_reg == R_DIFF)
        begin
            ax_reg <= diff_x[DW-1:0];
            ay_reg <= diff_y[DW-1:0];
        end
        if (state_reg == R_PROD)
        begin
            pxx_reg <= ax_reg * ax_reg;
            pyy_reg <= ay_reg * ay_reg;
            pxy_reg <= ax_reg * ay_reg;
        end
        if (state_reg == R_ACC)
        begin
            sxx_reg <= sxx_reg + SUM_W'($unsigned(pxx_reg));
            syy_reg <= syy_reg + SUM_W'($unsigned(pyy_reg));
            sxy_reg <= sxy_reg + (SUM_W+1)'(pxy_reg);
        end
    end

    assign done = done_reg;
    assign sxx  = sxx_reg;
    assign syy  = syy_reg;
    assign sxy  = sxy_reg;
endmodule
`default_nettype wire

/* rtl/core/srcc_mul.sv */
`timescale 1ns / 1ps
`default_nettype none
module srcc_mul #(
    parameter int A_W = 64,
    parameter int B_W = 32
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [A_W-1:0]     a,
    input  wire logic [B_W-1:0]     b,
    output logic                    done,
    output logic [A_W+B_W-1:0]      product
);
    localparam int NW = $clog2(B_W + 1);

    logic [A_W+B_W-1:0] acc_reg, ash_reg;
    logic [B_W-1:0]     bsh_reg;
    logic [NW-1:0]      cnt_reg;
    logic               busy_reg, done_reg;

    // shift-add, one multiplier bit per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == NW'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= NW'(B_W);
            end
            else if (busy_reg)
            begin
                cnt_reg  <= cnt_reg - NW'(1);
                busy_reg <= (cnt_reg != NW'(1));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= '0;
            ash_reg <= (A_W+B_W)'(a);
            bsh_reg <= b;
        end
        else if (busy_reg)
        begin
            if (bsh_reg[0])
            begin
                acc_reg <= acc_reg + ash_reg;
            end
            ash_reg <= ash_reg << 1;
            bsh_reg <= bsh_reg >> 1;
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;
endmodule
`default_nettype wire

/* rtl/core/srcc_root.sv */
`timescale 1ns / 1ps
`default_nettype none
module srcc_root #(
    parameter int MAX_POINTS = 1024
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 start,
    input  wire logic [3*$clog2(MAX_POINTS+1)-1:0]    sxx,
    input  wire logic [3*$clog2(MAX_POINTS+1)-1:0]    syy,
    input  wire logic signed [3*$clog2(MAX_POINTS+1):0] sxy,
    output logic                                      done,
    output logic signed [srcc_pkg::RHO_W-1:0]         rho,
    output logic                                      degenerate
);
    localparam int SUM_W = 3 * $clog2(MAX_POINTS + 1);
    localparam int PW    = 2 * SUM_W;
    localparam int BW    = (SUM_W > srcc_pkg::Q2_W) ? SUM_W : srcc_pkg::Q2_W;
    localparam int MW    = PW + BW;
    localparam int QW    = srcc_pkg::Q_W;

    localparam logic [2:0] T_IDLE   = 3'd0;
    localparam logic [2:0] T_PSTART = 3'd1;
    localparam logic [2:0] T_PWAIT  = 3'd2;
    localparam logic [2:0] T_RWAIT  = 3'd3;
    localparam logic [2:0] T_MID    = 3'd4;
    localparam logic [2:0] T_SQ     = 3'd5;
    localparam logic [2:0] T_SSTART = 3'd6;
    localparam logic [2:0] T_SWAIT  = 3'd7;

    logic [2:0]          state_reg;
    logic [SUM_W-1:0]    mag_reg, xx_reg, yy_reg;
    logic                neg_reg;
    logic [PW-1:0]       p_reg;
    logic [MW-1:0]       rhs_reg;
    logic [QW-1:0]       lo_reg, hi_reg, mid_reg;
    logic [BW-1:0]       q2_reg;
    logic                done_reg, deg_reg;
    logic signed [srcc_pkg::RHO_W-1:0] rho_reg;
    logic                mul_start, mul_done;
    logic [PW-1:0]       mul_a;
    logic [BW-1:0]       mul_b;
    logic [MW-1:0]       mul_p;
    logic [QW:0]         mid_sum;
    logic [2*QW-1:0]     mid_sq;

    assign mid_sum   = {1'b0, lo_reg} + {1'b0, hi_reg} + (QW+1)'(1);
    assign mid_sq    = (2*QW)'(mid_reg) * (2*QW)'(mid_reg);
    assign mul_start = (state_reg == T_PSTART) || (state_reg == T_SSTART)
                       || (state_reg == T_PWAIT && mul_done);

    always_comb
    begin
        unique case (state_reg)
            T_PSTART:
            begin
                mul_a = PW'(xx_reg);
                mul_b = BW'(yy_reg);
            end
            T_PWAIT:
            begin
                mul_a = PW'(mag_reg);
                mul_b = BW'(mag_reg);
            end
            default:
            begin
                mul_a = p_reg;
                mul_b = q2_reg;
            end
        endcase
    end

    srcc_mul #(.A_W(PW), .B_W(BW)) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_p)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= T_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                T_IDLE:
                begin
                    if (start)
                    begin
                        if (sxx == '0 || syy == '0)
                        begin
                            done_reg <= 1'b1;
                        end
                        else
                        begin
                            state_reg <= T_PSTART;
                        end
                    end
                end
                T_PSTART: state_reg <= T_PWAIT;
                T_PWAIT:
                begin
                    if (mul_done)
                    begin
                        state_reg <= T_RWAIT;
                    end
                end
                T_RWAIT:
                begin
                    if (mul_done)
                    begin
                        state_reg <= T_MID;
                    end
                end
                T_MID:
                begin
                    if (lo_reg < hi_reg)
                    begin
                        state_reg <= T_SQ;
                    end
                    else
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= T_IDLE;
                    end
                end
                T_SQ:     state_reg <= T_SSTART;
                T_SSTART: state_reg <= T_SWAIT;
                T_SWAIT:
                begin
                    if (mul_done)
                    begin
                        state_reg <= T_MID;
                    end
                end
                default:  state_reg <= T_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == T_IDLE && start)
        begin
            xx_reg  <= sxx;
            yy_reg  <= syy;
            neg_reg <= sxy[SUM_W];
            mag_reg <= sxy[SUM_W] ? SUM_W'(-sxy) : SUM_W'(sxy);
            deg_reg <= (sxx == '0 || syy == '0);
            rho_reg <= '0;
            lo_reg  <= '0;
            hi_reg  <= srcc_pkg::RHO_ONE;
        end
        if (state_reg == T_PWAIT && mul_done)
        begin
            p_reg <= mul_p[PW-1:0];
        end
        if (state_reg == T_RWAIT && mul_done)
        begin
            rhs_reg <= MW'(mul_p[PW-1:0]) << srcc_pkg::FRAC_SHIFT;
        end
        if (state_reg == T_MID)
        begin
            mid_reg <= mid_sum[QW:1];
            if (!(lo_reg < hi_reg))
            begin
                rho_reg <= neg_reg ? -$signed(srcc_pkg::RHO_W'(lo_reg))
                                   : $signed(srcc_pkg::RHO_W'(lo_reg));
            end
        end
        if (state_reg == T_SQ)
        begin
            q2_reg <= BW'(mid_sq);
        end
        if (state_reg == T_SWAIT && mul_done)
        begin
            if (mul_p <= rhs_reg)
            begin
                lo_reg <= mid_reg;
            end
            else
            begin
                hi_reg <= mid_reg - QW'(1);
            end
        end
    end

    assign done       = done_reg;
    assign rho        = rho_reg;
    assign degenerate = deg_reg;
endmodule
`default_nettype wire

/* rtl/core/spearman_rank_correlation.sv */
`timescale 1ns / 1ps
`default_nettype none
// channel   dir  payload                               handshake
// samples   in   x_value, y_value, last_point          valid/ready
// result    out  rho, degenerate, points_used          valid/ready
//
// pairs load at one per cycle into the two sample memories while in the load state
// after the last pair, ranking makes one memory read per compared sample;
// the correlation then runs two products and up to 15 search steps on a
// shift-add multiplier of B = max(3*clog2(MAX_POINTS+1),29) bits; a
// degenerate set skips it
// the result register lets the next data set load while a result waits
// reset clears all control state; sample memories need no clearing
module spearman_rank_correlation #(
    parameter int MAX_POINTS  = 1024,
    parameter int SAMPLE_BITS = 32
) (
    input wire logic    clk,
    input wire logic    rst_n,
    srcc_in_if.sink     samples,
    srcc_out_if.source  result
);
    localparam int CW    = $clog2(MAX_POINTS + 1);
    localparam int AW    = $clog2(MAX_POINTS);
    localparam int SUM_W = 3 * CW;

    localparam logic [1:0] S_LOAD = 2'd0;
    localparam logic [1:0] S_RANK = 2'd1;
    localparam logic [1:0] S_ROOT = 2'd2;
    localparam logic [1:0] S_HOLD = 2'd3;

    logic [1:0]                    state_reg;
    logic [CW-1:0]                 cnt_reg, n_reg;
    logic                          take, room;
    logic [CW-1:0]                 n_after;
    logic                          rank_start_reg;
    logic [AW-1:0]                 raddr;
    logic signed [SAMPLE_BITS-1:0] x_key, y_key, x_in, y_in;
    logic                          rank_done, root_done, root_deg;
    logic [SUM_W-1:0]              sxx, syy;
    logic signed [SUM_W:0]         sxy;
    logic signed [srcc_pkg::RHO_W-1:0] root_rho;
    logic                          out_valid_reg;
    logic signed [srcc_pkg::RHO_W-1:0] rho_reg;
    logic                          deg_reg;
    logic [srcc_pkg::PTS_W-1:0]    pts_reg;

    assign samples.ready = (state_reg == S_LOAD);
    assign take          = samples.valid && samples.ready;
    assign room          = (cnt_reg < CW'(MAX_POINTS));
    assign n_after       = room ? cnt_reg + CW'(1) : cnt_reg;
    assign x_in          = SAMPLE_BITS'(samples.x_value);
    assign y_in          = SAMPLE_BITS'(samples.y_value);

    srcc_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_POINTS)) u_xram (
        .clk   (clk),
        .we    (take && room),
        .waddr (cnt_reg[AW-1:0]),
        .wdata (x_in),
        .raddr (raddr),
        .rdata (x_key)
    );

    srcc_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_POINTS)) u_yram (
        .clk   (clk),
        .we    (take && room),
        .waddr (cnt_reg[AW-1:0]),
        .wdata (y_in),
        .raddr (raddr),
        .rdata (y_key)
    );

    srcc_rank #(.MAX_POINTS(MAX_POINTS), .SAMPLE_BITS(SAMPLE_BITS)) u_rank (
        .clk   (clk),
        .rst_n (rst_n),
        .start (rank_start_reg),
        .n     (n_reg),
        .raddr (raddr),
        .x_key (x_key),
        .y_key (y_key),
        .done  (rank_done),
        .sxx   (sxx),
        .syy   (syy),
        .sxy   (sxy)
    );

    srcc_root #(.MAX_POINTS(MAX_POINTS)) u_root (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (rank_done),
        .sxx        (sxx),
        .syy        (syy),
        .sxy        (sxy),
        .done       (root_done),
        .rho        (root_rho),
        .degenerate (root_deg)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_LOAD;
            cnt_reg        <= '0;
            n_reg          <= '0;
            rank_start_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            rank_start_reg <= 1'b0;
            if (state_reg == S_HOLD && (!out_valid_reg || result.ready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_LOAD:
                begin
                    if (take)
                    begin
                        if (samples.last_point)
                        begin
                            n_reg          <= n_after;
                            cnt_reg        <= '0;
                            rank_start_reg <= 1'b1;
                            state_reg      <= S_RANK;
                        end
                        else
                        begin
                            cnt_reg <= n_after;
                        end
                    end
                end
                S_RANK:
                begin
                    if (rank_done)
                    begin
                        state_reg <= S_ROOT;
                    end
                end
                S_ROOT:
                begin
                    if (root_done)
                    begin
                        state_reg <= S_HOLD;
                    end
                end
                S_HOLD:
                begin
                    if (!out_valid_reg || result.ready)
                    begin
                        state_reg <= S_LOAD;
                    end
                end
                default: state_reg <= S_LOAD;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_HOLD && (!out_valid_reg || result.ready))
        begin
            rho_reg <= root_rho;
            deg_reg <= root_deg;
            pts_reg <= srcc_pkg::PTS_W'(n_reg);
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.rho         = rho_reg;
    assign result.degenerate  = deg_reg;
    assign result.points_used = pts_reg;
endmodule
`default_nettype wire

/* rtl/core/srcc_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
module srcc_checker (
    input wire logic                               clk,
    input wire logic                               rst_n,
    input wire logic                               out_valid,
    input wire logic                               out_ready,
    input wire logic signed [srcc_pkg::RHO_W-1:0]  rho,
    input wire logic                               degenerate,
    input wire logic [srcc_pkg::PTS_W-1:0]         points_used
);
    // stalled result keeps its rho and degenerate payload
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(rho) && $stable(degenerate))
        else $error("result changed while stalled");

    a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && degenerate |-> rho == '0)
        else $error("degenerate result with nonzero rho");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> rho <= 16'sd16384 && rho >= -16'sd16384)
        else $error("rho out of range");

    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && points_used == 11'd1 |-> degenerate)
        else $error("single pair not flagged degenerate");
endmodule

bind spearman_rank_correlation srcc_checker u_srcc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .rho         (result.rho),
    .degenerate  (result.degenerate),
    .points_used (result.points_used)
);
`default_nettype wire
